// ===== rtl/core/fpdrf_pkg.sv =====
// ----------------------------------------------------------------------------
// fpdrf_pkg
// Shared types and constants for the fixed-point decimal row formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpdrf_pkg;

    localparam int ROW0_COLUMNS_DEFAULT = 8;
    localparam int ROW1_COLUMNS_DEFAULT = 7;

    localparam int MAX_ITEMS  = 8;
    localparam int DIGITS     = 10;
    localparam int BIN_W      = 32;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int STEP_W     = $clog2(BIN_W);
    localparam int LEN_W      = 4;
    localparam int RES_W      = 3;
    localparam int PAD_W      = 2;
    localparam int SYM_W      = 4;
    localparam int COL_W      = 3;

    localparam logic [PAD_W-1:0] PAD_NONE  = 2'd0;
    localparam logic [PAD_W-1:0] PAD_BLANK = 2'd1;
    localparam logic [PAD_W-1:0] PAD_ZERO  = 2'd2;

    localparam logic [SYM_W-1:0] SYM_ZERO  = 4'd0;
    localparam logic [SYM_W-1:0] SYM_BLANK = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EVAL,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/fixed_point_decimal_row_formatter.sv =====
// ----------------------------------------------------------------------------
// fixed_point_decimal_row_formatter
// Converts an unsigned fixed-point value into one beat per display column.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one value
//   with its decimal places, row select and padding mode. The master channel
//   (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast) returns 1 to 8 column beats,
//   leftmost first, m_tlast on the final one.
//   Conversion runs shift-and-add-3 through one digit adjust/shift unit,
//   an evaluation state then sizes the row, and the row goes out at one beat
//   per cycle while m_tready is high.
//   s_tready is high only while the block is idle, so items are handled one
//   at a time. When the receiver stalls, the current beat holds on the
//   master channel until it is taken.
//   Reset returns the sequencer to idle with no beat pending.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_decimal_row_formatter #(
    parameter int ROW0_COLUMNS = fpdrf_pkg::ROW0_COLUMNS_DEFAULT,
    parameter int ROW1_COLUMNS = fpdrf_pkg::ROW1_COLUMNS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], resolution[34:32], zero fill
    input  wire logic [2:0]  s_tuser,   // row[0], pad_mode[2:1]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // column[2:0], symbol[6:3], dot[7]
    output logic [0:0]       m_tuser,   // overflow[0]
    output logic             m_tlast
);

    import fpdrf_pkg::*;

    localparam int ROW0_CLAMP = (ROW0_COLUMNS > MAX_ITEMS) ? MAX_ITEMS :
                                (ROW0_COLUMNS < 1) ? 1 : ROW0_COLUMNS;
    localparam int ROW1_CLAMP = (ROW1_COLUMNS > MAX_ITEMS) ? MAX_ITEMS :
                                (ROW1_COLUMNS < 1) ? 1 : ROW1_COLUMNS;
    localparam logic [LEN_W-1:0] ROW0_W = LEN_W'(ROW0_CLAMP);
    localparam logic [LEN_W-1:0] ROW1_W = LEN_W'(ROW1_CLAMP);

    state_t              state_reg, state_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RES_W-1:0]    res_reg, res_next;
    logic                row_reg, row_next;
    logic [PAD_W-1:0]    pad_reg, pad_next;
    logic [LEN_W-1:0]    ndig_reg, ndig_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic [COL_W-1:0]    col_reg, col_next;

    logic [BCD_W-1:0]    bcd_adj;
    logic [LEN_W-1:0]    top_dig;
    logic [LEN_W-1:0]    ndig_min;
    logic [LEN_W-1:0]    row_width;
    logic [LEN_W-1:0]    pos;
    logic [SYM_W-1:0]    sym;
    logic                dot;
    logic                is_last;

    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        top_dig = LEN_W'(1);
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] != 4'd0)
                top_dig = LEN_W'(d + 1);
        end
        if (top_dig < ({1'b0, res_reg} + LEN_W'(1)))
            ndig_min = {1'b0, res_reg} + LEN_W'(1);
        else
            ndig_min = top_dig;
        row_width = row_reg ? ROW1_W : ROW0_W;
    end

    always_comb
    begin
        pos     = len_reg - LEN_W'(1) - {1'b0, col_reg};
        is_last = (pos == LEN_W'(0));
        if (pos < ndig_reg)
            sym = bcd_reg[4*pos[COL_W-1:0] +: 4];
        else if (pad_reg == PAD_BLANK)
            sym = SYM_BLANK;
        else
            sym = SYM_ZERO;
        dot = (res_reg != '0) && (pos == {1'b0, res_reg});
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {dot, sym, col_reg};
    assign m_tuser  = ovf_reg;
    assign m_tlast  = is_last;

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        row_next   = row_reg;
        pad_next   = pad_reg;
        ndig_next  = ndig_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        col_next   = col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bin_next   = s_tdata[BIN_W-1:0];
                    res_next   = s_tdata[BIN_W +: RES_W];
                    row_next   = s_tuser[0];
                    pad_next   = s_tuser[2:1];
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
                bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(BIN_W - 1))
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                ndig_next = ndig_min;
                ovf_next  = 1'b0;
                if (ndig_min > row_width)
                begin
                    len_next = row_width;
                    ovf_next = 1'b1;
                end
                else if ((pad_reg inside {PAD_BLANK, PAD_ZERO}) && ndig_min < row_width)
                    len_next = row_width;
                else
                    len_next = ndig_min;
                col_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (is_last)
                        state_next = ST_IDLE;
                    else
                        col_next = col_reg + COL_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        step_reg <= step_next;
        res_reg  <= res_next;
        row_reg  <= row_next;
        pad_reg  <= pad_next;
        ndig_reg <= ndig_next;
        len_reg  <= len_next;
        ovf_reg  <= ovf_next;
        col_reg  <= col_next;
    end

endmodule

`default_nettype wire
